// File: design/byterun_rle_encoder_core_macros.svh
// Assertion macros for the ByteRun1 encoder core.
// Used by byterun_rle_encoder_core.sv; expects clk_i and rst_ni in scope.
`ifndef BYTERUN_RLE_ENCODER_CORE_MACROS_SVH
`define BYTERUN_RLE_ENCODER_CORE_MACROS_SVH

// Checks a property on every rising clock edge while out of reset.
`define BRLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define BRLE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: design/brle_pkg.sv
// Shared types and constants of the ByteRun1 encoder core.
// No dependencies; imported by every module of the block.
`default_nettype none

package brle_pkg;

  // Literal byte store geometry.
  localparam int unsigned LitDepth = 64;
  localparam int unsigned LitAddrW = $clog2(LitDepth);

  // Kind of packet that the back end writes out.
  typedef enum logic {
    CmdRun,
    CmdLit
  } brle_kind_e;

  // One packet command: a run of len copies of data, or len stored literals.
  typedef struct packed {
    brle_kind_e  kind;
    logic [7:0]  len;
    logic [7:0]  data;
  } brle_cmd_t;

  // Write port into the literal store.
  typedef struct packed {
    logic                we;
    logic [LitAddrW-1:0] addr;
    logic [7:0]          data;
  } brle_wr_t;

  // Status of the back end toward the front end and the checks.
  typedef struct packed {
    logic lit_active;
    logic lit_done;
  } brle_bk_stat_t;

endpackage

`default_nettype wire

// File: design/brle_front.sv
// Front end of the ByteRun1 encoder: classifies each input byte, updates the
// packing state, writes literals to the store and queues packet commands.
// Depends on brle_pkg.
`default_nettype none

module brle_front #(
  parameter int unsigned MAX_LITERAL = 60,
  parameter int unsigned MAX_RUN     = 128
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          in_byte_i,
  input  wire logic                in_row_end_i,
  output brle_pkg::brle_wr_t       wr_o,
  output logic                     cmd_push_o,
  output brle_pkg::brle_cmd_t      cmd_o,
  input  wire logic                cmd_full_i,
  input  wire logic                lit_done_i,
  output logic                     lit_busy_o
);
  import brle_pkg::*;

  typedef enum logic [1:0] {
    ModeUnknown = 2'd0,
    ModeRun     = 2'd1,
    ModeLit     = 2'd2,
    ModeMaybe   = 2'd3
  } mode_e;

  localparam logic [7:0] MaxLit = 8'(MAX_LITERAL);
  localparam logic [7:0] MaxRun = 8'(MAX_RUN);

  mode_e       mode_q, mode_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [7:0]  prior_q;
  logic        started_q, started_d;
  logic        lit_busy_q;
  logic        pend0_q, pend1_q;
  brle_cmd_t   cmd0_q, cmd1_q;

  logic        accept;
  logic        we_c;
  logic [LitAddrW-1:0] waddr_c;
  logic        ca_v, cb_v;
  brle_cmd_t   ca, cb;
  logic        has_lit;

  function automatic brle_cmd_t run_cmd(logic [7:0] len, logic [7:0] b);
    brle_cmd_t c;
    c.kind = CmdRun;
    c.len  = len;
    c.data = b;
    return c;
  endfunction

  function automatic brle_cmd_t lit_cmd(logic [7:0] len);
    brle_cmd_t c;
    c.kind = CmdLit;
    c.len  = len;
    c.data = 8'd0;
    return c;
  endfunction

  // A new byte is taken once earlier commands are queued and no literal drains.
  assign in_ready_o = !pend0_q && !lit_busy_q;
  assign accept     = in_valid_i && in_ready_o;

  // Classification of the offered byte against the packing state.
  always_comb begin
    logic eq;
    eq        = (in_byte_i == prior_q);
    mode_d    = mode_q;
    cnt_d     = cnt_q;
    started_d = started_q;
    we_c      = 1'b0;
    waddr_c   = '0;
    ca_v      = 1'b0;
    ca        = run_cmd(8'd0, 8'd0);
    cb_v      = 1'b0;
    cb        = run_cmd(8'd0, 8'd0);

    if (!started_q) begin
      we_c      = 1'b1;
      waddr_c   = '0;
      mode_d    = ModeUnknown;
      cnt_d     = 8'd1;
      started_d = 1'b1;
    end else begin
      unique case (mode_q)
        ModeUnknown: begin
          if (eq) begin
            mode_d = ModeRun;
          end else begin
            we_c    = 1'b1;
            waddr_c = LitAddrW'(1);
            mode_d  = ModeLit;
          end
          cnt_d = 8'd2;
        end
        ModeRun: begin
          if (eq) begin
            cnt_d = cnt_q + 8'd1;
          end else begin
            ca_v    = 1'b1;
            ca      = run_cmd(cnt_q, prior_q);
            we_c    = 1'b1;
            waddr_c = '0;
            mode_d  = ModeUnknown;
            cnt_d   = 8'd1;
          end
        end
        ModeLit: begin
          if (eq) begin
            if ((cnt_q + 8'd1) >= MaxLit) begin
              // The pair would fill the literal: close it and start a run.
              ca_v   = 1'b1;
              ca     = lit_cmd(cnt_q - 8'd1);
              mode_d = ModeRun;
              cnt_d  = 8'd2;
            end else begin
              we_c    = 1'b1;
              waddr_c = LitAddrW'(cnt_q);
              mode_d  = ModeMaybe;
            end
          end else begin
            we_c    = 1'b1;
            waddr_c = LitAddrW'(cnt_q);
            cnt_d   = cnt_q + 8'd1;
          end
        end
        ModeMaybe: begin
          if (eq) begin
            // Third equal byte: the literal ends before the pair.
            ca_v   = 1'b1;
            ca     = lit_cmd(cnt_q - 8'd1);
            mode_d = ModeRun;
            cnt_d  = 8'd3;
          end else begin
            we_c    = 1'b1;
            waddr_c = LitAddrW'(cnt_q + 8'd1);
            cnt_d   = cnt_q + 8'd2;
            mode_d  = ModeLit;
          end
        end
        default: begin
          mode_d = ModeUnknown;
        end
      endcase
    end

    // A packet that reaches its limit goes out at once.
    if (mode_d == ModeRun && cnt_d >= MaxRun) begin
      cb_v      = 1'b1;
      cb        = run_cmd(cnt_d, in_byte_i);
      started_d = 1'b0;
      mode_d    = ModeUnknown;
      cnt_d     = 8'd1;
    end else if (mode_d == ModeLit && cnt_d >= MaxLit) begin
      cb_v      = 1'b1;
      cb        = lit_cmd(cnt_d);
      started_d = 1'b0;
      mode_d    = ModeUnknown;
      cnt_d     = 8'd1;
    end

    // End of row flushes whatever is pending.
    if (in_row_end_i) begin
      if (started_d) begin
        cb_v = 1'b1;
        unique case (mode_d)
          ModeRun:     cb = run_cmd(cnt_d, in_byte_i);
          ModeLit:     cb = lit_cmd(cnt_d);
          ModeMaybe:   cb = lit_cmd(cnt_d + 8'd1);
          ModeUnknown: cb = lit_cmd(8'd1);
          default:     cb = lit_cmd(8'd1);
        endcase
      end
      started_d = 1'b0;
      mode_d    = ModeUnknown;
      cnt_d     = 8'd1;
    end
  end

  assign has_lit = (ca_v && ca.kind == CmdLit) || (cb_v && cb.kind == CmdLit);

  assign wr_o.we   = accept && we_c;
  assign wr_o.addr = waddr_c;
  assign wr_o.data = in_byte_i;

  assign cmd_push_o = pend0_q && !cmd_full_i;
  assign cmd_o      = cmd0_q;
  assign lit_busy_o = lit_busy_q;

  // Packing state, pending command slots and the literal interlock.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeUnknown;
      cnt_q      <= 8'd1;
      prior_q    <= 8'd0;
      started_q  <= 1'b0;
      lit_busy_q <= 1'b0;
      pend0_q    <= 1'b0;
      pend1_q    <= 1'b0;
      cmd0_q     <= '0;
      cmd1_q     <= '0;
    end else begin
      if (accept) begin
        mode_q    <= mode_d;
        cnt_q     <= cnt_d;
        prior_q   <= in_byte_i;
        started_q <= started_d;
        if (ca_v) begin
          cmd0_q  <= ca;
          pend0_q <= 1'b1;
          cmd1_q  <= cb;
          pend1_q <= cb_v;
        end else begin
          cmd0_q  <= cb;
          pend0_q <= cb_v;
          pend1_q <= 1'b0;
        end
        lit_busy_q <= has_lit;
      end else begin
        if (cmd_push_o) begin
          cmd0_q  <= cmd1_q;
          pend0_q <= pend1_q;
          pend1_q <= 1'b0;
        end
        if (lit_done_i) begin
          lit_busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: design/brle_cmd_fifo.sv
// Command queue between the front and back ends of the ByteRun1 encoder.
// Depends on brle_pkg for the command type.
`default_nettype none

module brle_cmd_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire brle_pkg::brle_cmd_t cmd_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output brle_pkg::brle_cmd_t      cmd_o,
  output logic                     empty_o
);
  import brle_pkg::*;

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  brle_cmd_t          slot_q [DEPTH];
  logic [AddrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = slot_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AddrW'(DEPTH - 1)) ? '0 : wr_ptr_q + AddrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AddrW'(DEPTH - 1)) ? '0 : rd_ptr_q + AddrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  // Queue slots.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// File: design/brle_back.sv
// Back end of the ByteRun1 encoder: holds the literal store, takes packet
// commands from the queue and writes header and data words to the output.
// Depends on brle_pkg.
`default_nettype none

module brle_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire brle_pkg::brle_wr_t  wr_i,
  input  wire logic                cmd_valid_i,
  input  wire brle_pkg::brle_cmd_t cmd_i,
  output logic                     cmd_pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [7:0]               out_byte_o,
  output logic                     out_last_o,
  output brle_pkg::brle_bk_stat_t  stat_o
);
  import brle_pkg::*;

  typedef enum logic [1:0] {
    StIdle    = 2'd0,
    StHdr     = 2'd1,
    StRunData = 2'd2,
    StLitData = 2'd3
  } state_e;

  state_e              state_q;
  brle_cmd_t           cur_q;
  logic [LitAddrW-1:0] idx_q;
  logic                out_valid_q;
  logic [7:0]          out_byte_q;
  logic                out_last_q;

  logic [7:0]          store_q [LitDepth];
  logic [7:0]          rdata_q;
  logic                rd_en;
  logic [LitAddrW-1:0] rd_addr;

  logic                out_free;
  logic                lit_last;

  assign out_free  = !out_valid_q || out_ready_i;
  assign lit_last  = ({{(8 - LitAddrW){1'b0}}, idx_q} == (cur_q.len - 8'd1));
  assign cmd_pop_o = (state_q == StIdle) && cmd_valid_i;

  // Store read: the header prefetches entry zero, each data word the next one.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (state_q == StHdr && cur_q.kind == CmdLit && out_free) begin
      rd_en = 1'b1;
    end else if (state_q == StLitData && out_free && !lit_last) begin
      rd_en   = 1'b1;
      rd_addr = idx_q + LitAddrW'(1);
    end
  end

  assign stat_o.lit_active = (state_q == StLitData) ||
                             (state_q == StHdr && cur_q.kind == CmdLit);
  assign stat_o.lit_done   = (state_q == StLitData) && out_free && lit_last;

  // Literal store, written by the front end.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      store_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en) begin
      rdata_q <= store_q[rd_addr];
    end
  end

  // Packet sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cur_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= 8'd0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (cmd_valid_i) begin
            cur_q   <= cmd_i;
            state_q <= StHdr;
          end
        end
        StHdr: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_last_q  <= 1'b0;
            if (cur_q.kind == CmdRun) begin
              out_byte_q <= 8'(9'd257 - {1'b0, cur_q.len});
              state_q    <= StRunData;
            end else begin
              out_byte_q <= cur_q.len - 8'd1;
              idx_q      <= '0;
              state_q    <= StLitData;
            end
          end
        end
        StRunData: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_byte_q  <= cur_q.data;
            out_last_q  <= 1'b1;
            state_q     <= StIdle;
          end
        end
        StLitData: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_byte_q  <= rdata_q;
            out_last_q  <= lit_last;
            idx_q       <= idx_q + LitAddrW'(1);
            if (lit_last) begin
              state_q <= StIdle;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

// File: design/byterun_rle_encoder_core.sv
// Top level of the ByteRun1 (PackBits) row encoder core.
// Depends on brle_pkg, brle_front, brle_cmd_fifo, brle_back and the macros header.
//
// Usage: uncompressed bytes enter on the slave stream (tdata = the byte, tlast
// marks the last byte of a row); the compressed stream leaves on the master
// stream (tdata = header or data byte, tlast marks the last word of a packet).
// A byte that produces no packet does not hold off the next byte. A byte that
// closes packets places one or two commands in the queue, one per cycle while
// the queue has room, before the next byte is taken. The back end fetches a
// command and then sends its output words in order: a run is 2 words, a
// literal of L bytes is L+1 words read from the literal store, one per cycle
// while the receiver takes them. While a literal packet is still being read
// out of the store, the input is held off; runs overlap with input. After
// reset the encoder is idle with no row started; the literal store is not
// cleared and needs no clearing pass. When the receiver stalls, the output
// word holds, the queue fills and the input is then held off.
`default_nettype none

module byterun_rle_encoder_core #(
  parameter int unsigned MAX_LITERAL = 60,
  parameter int unsigned MAX_RUN     = 128,
  parameter int unsigned CMD_DEPTH   = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic       s_axis_tlast_i,   // row_end
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] out_byte
  output logic            m_axis_tlast_o    // packet_last
);
  import brle_pkg::*;

  `include "byterun_rle_encoder_core_macros.svh"

  brle_wr_t      store_wr;
  brle_cmd_t     fe_cmd, q_cmd;
  logic          fe_push, q_full, q_empty, bk_pop;
  logic          fe_lit_busy;
  brle_bk_stat_t bk_stat;

  // Front end: classification and packing state.
  brle_front #(
    .MAX_LITERAL (MAX_LITERAL),
    .MAX_RUN     (MAX_RUN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_byte_i    (s_axis_tdata_i),
    .in_row_end_i (s_axis_tlast_i),
    .wr_o         (store_wr),
    .cmd_push_o   (fe_push),
    .cmd_o        (fe_cmd),
    .cmd_full_i   (q_full),
    .lit_done_i   (bk_stat.lit_done),
    .lit_busy_o   (fe_lit_busy)
  );

  // Command queue.
  brle_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .cmd_i   (fe_cmd),
    .full_o  (q_full),
    .pop_i   (bk_pop),
    .cmd_o   (q_cmd),
    .empty_o (q_empty)
  );

  // Back end: packet output and literal store.
  brle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (store_wr),
    .cmd_valid_i (!q_empty),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (bk_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .stat_o      (bk_stat)
  );

  // The store is never written while a literal packet is read from it.
  `BRLE_ASSERT(a_no_store_clobber, !(store_wr.we && bk_stat.lit_active), "store written during literal readout")
  // A literal readout is always covered by the front end's interlock.
  `BRLE_ASSERT(a_lit_interlock, bk_stat.lit_active |-> fe_lit_busy, "literal readout without interlock")
  // After the last literal word the back end leaves the literal readout.
  `BRLE_ASSERT(a_lit_done_ends, bk_stat.lit_done |=> !bk_stat.lit_active, "literal readout did not end")

endmodule

`default_nettype wire

// File: tb/tb_byterun_rle_encoder_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for byterun_rle_encoder_core, the ByteRun1 row encoder.
// Depends on brle_pkg and the core; a scoreboard class predicts the packed stream.

// Encoder modes as the predictor tracks them.
typedef enum logic [1:0] {
  ModeUnknown,
  ModeRun,
  ModeLit,
  ModeMaybe
} pack_mode_e;

// One compressed output word: header or data byte, and the end-of-packet flag.
typedef struct packed {
  logic [7:0] value;
  logic       last;
} brle_word_t;

// Predicts the compressed words for each accepted byte and checks the outputs.
class brle_scoreboard #(int unsigned MaxLiteral = 60, int unsigned MaxRun = 128);
  pack_mode_e mode;
  logic [7:0] pend_len;
  logic [7:0] prev_byte;
  bit         row_open;
  logic [7:0] lit_buf [brle_pkg::LitDepth];
  brle_word_t packed_words [$];
  int         errors;
  int         words_out;

  function new();
    go_idle();
    foreach (lit_buf[i]) lit_buf[i] = 8'h00;
    errors    = 0;
    words_out = 0;
  endfunction

  function void go_idle();
    row_open  = 1'b0;
    mode      = ModeUnknown;
    pend_len  = 8'd1;
    prev_byte = 8'h00;
  endfunction

  function int pending();
    return packed_words.size();
  endfunction

  function void put_word(logic [7:0] value, logic last);
    brle_word_t w;
    w.value = value;
    w.last  = last;
    packed_words.push_back(w);
  endfunction

  // A run packet: header is (1 - length) modulo 256, then the repeated byte.
  function void put_run(logic [7:0] len, logic [7:0] value);
    logic [7:0] hdr;
    hdr = 8'd1 - len;
    put_word(hdr, 1'b0);
    put_word(value, 1'b1);
  endfunction

  // A literal packet: header is length minus 1, then the stored bytes.
  function void put_literal(int len);
    logic [7:0] hdr;
    hdr = 8'(len - 1);
    put_word(hdr, 1'b0);
    for (int i = 0; i < len; i++) begin
      put_word(lit_buf[i % brle_pkg::LitDepth], i == len - 1);
    end
  endfunction

  // Advances the encoder state by one accepted byte.
  function void note_input(logic [7:0] b, logic row_end);
    logic [7:0] old;
    int         cnt;
    old       = prev_byte;
    cnt       = int'(pend_len);
    prev_byte = b;
    if (!row_open) begin
      lit_buf[0] = b;
      mode       = ModeUnknown;
      cnt        = 1;
      row_open   = 1'b1;
    end else begin
      case (mode)
        ModeUnknown: begin
          if (b == old) begin
            mode = ModeRun;
            cnt  = 2;
          end else begin
            lit_buf[1] = b;
            mode       = ModeLit;
            cnt        = 2;
          end
        end
        ModeRun: begin
          if (b == old) begin
            cnt++;
          end else begin
            put_run(8'(cnt), old);
            lit_buf[0] = b;
            mode       = ModeUnknown;
            cnt        = 1;
          end
        end
        ModeLit: begin
          if (b == old) begin
            // A pair that would fill the literal closes it and becomes a run.
            if (cnt + 1 >= int'(MaxLiteral)) begin
              put_literal(cnt - 1);
              mode = ModeRun;
              cnt  = 2;
            end else begin
              lit_buf[cnt % brle_pkg::LitDepth] = b;
              mode = ModeMaybe;
            end
          end else begin
            lit_buf[cnt % brle_pkg::LitDepth] = b;
            cnt++;
          end
        end
        default: begin
          // A third equal byte ends the literal and starts a run of three.
          if (b == old) begin
            put_literal(cnt - 1);
            mode = ModeRun;
            cnt  = 3;
          end else begin
            lit_buf[(cnt + 1) % brle_pkg::LitDepth] = b;
            cnt += 2;
            mode = ModeLit;
          end
        end
      endcase
    end
    pend_len = 8'(cnt);

    // Packets that reach their size limit leave at once.
    if (mode == ModeRun && cnt >= int'(MaxRun)) begin
      put_run(8'(cnt), b);
      go_idle();
    end else if (mode == ModeLit && cnt >= int'(MaxLiteral)) begin
      put_literal(cnt);
      go_idle();
    end

    // The end of a row flushes whatever is pending.
    if (row_end) begin
      if (row_open) begin
        case (mode)
          ModeRun:   put_run(pend_len, b);
          ModeLit:   put_literal(int'(pend_len));
          ModeMaybe: put_literal(int'(pend_len) + 1);
          default:   put_literal(1);
        endcase
      end
      go_idle();
    end
  endfunction

  task report(string msg);
    $display("ERROR: %0t word %0d: %s", $realtime, words_out, msg);
    errors++;
  endtask

  // Compares one accepted output word with the oldest predicted word.
  task check_word(logic [7:0] value, logic last);
    brle_word_t want;
    if (packed_words.size() == 0) begin
      report($sformatf("unexpected word %02h last %0b", value, last));
    end else begin
      want = packed_words.pop_front();
      if (value !== want.value) begin
        report($sformatf("byte %02h, predicted %02h", value, want.value));
      end
      if (last !== want.last) begin
        report($sformatf("packet end flag %0b, predicted %0b", last, want.last));
      end
    end
    words_out++;
  endtask
endclass

module tb_byterun_rle_encoder_core;
  localparam int unsigned MaxLiteral = 60;
  localparam int unsigned MaxRun     = 128;
  localparam int          CycleLimit = 6000000;
  localparam int          HoldCycles = 400;
  localparam int          DrainCycles = 200;
  localparam int          RandomItems = 290;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid_i;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i;   // [7:0] data_byte
  logic       s_axis_tlast_i;   // row_end
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i;
  logic [7:0] m_axis_tdata_o;   // [7:0] out_byte
  logic       m_axis_tlast_o;   // packet_last

  logic       hold_off;
  int         accepted_words;
  int         hold_mark;
  int         cycle_count;
  logic [7:0] last_sent;

  brle_scoreboard #(MaxLiteral, MaxRun) sb;

  byterun_rle_encoder_core #(
    .MAX_LITERAL(MaxLiteral),
    .MAX_RUN    (MaxRun)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run limit in clock cycles.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Idle lengths: mostly none or short, now and then long.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offers one byte and waits until the encoder takes it. The ready line is
  // sampled in the middle of the cycle, so the value seen is the one at the edge.
  task automatic send_word(input logic [7:0] b, input logic row_end, input bit no_gap);
    int gap;
    bit rdy;
    gap = no_gap ? 0 : pick_idle();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= row_end;
    rdy = 1'b0;
    while (!rdy) begin
      @(negedge clk_i);
      rdy = s_axis_tready_o;
      @(posedge clk_i);
    end
    sb.note_input(b, row_end);
    accepted_words++;
    last_sent = b;
  endtask

  function automatic logic [7:0] other_byte(logic [7:0] b);
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == b) c = ~b;
    return c;
  endfunction

  // A run of one byte value; the row may end on its last byte.
  task automatic send_run(input int len, input logic [7:0] b, input logic row_end);
    for (int i = 0; i < len; i++) send_word(b, row_end && (i == len - 1), 1'b0);
  endtask

  // Bytes that each differ from the one before.
  task automatic send_distinct(input int len, input logic row_end);
    logic [7:0] b;
    b = last_sent;
    for (int i = 0; i < len; i++) begin
      b = other_byte(b);
      send_word(b, row_end && (i == len - 1), 1'b0);
    end
  endtask

  // A literal stretch that now and then holds pairs and triples.
  task automatic send_mixed(input int len, input logic row_end);
    logic [7:0] b;
    int         r;
    b = last_sent;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) b = other_byte(b);
      else if (r >= 85) b = 8'($urandom_range(0, 255));
      send_word(b, row_end && (i == len - 1), 1'b0);
    end
  endtask

  // Receiver: samples the output mid-cycle, checks accepted words at the edge
  // and stalls at random.
  initial begin : rx_side
    int         stall_left;
    int         free_left;
    int         r;
    bit         take;
    logic [7:0] w_byte;
    logic       w_last;
    stall_left = 0;
    free_left  = 0;
    forever begin
      @(negedge clk_i);
      take   = rst_ni && m_axis_tvalid_o && m_axis_tready_i;
      w_byte = m_axis_tdata_o;
      w_last = m_axis_tlast_o;
      @(posedge clk_i);
      if (take) begin
        sb.check_word(w_byte, w_last);
      end
      if (free_left > 0) begin
        free_left--;
      end else if (stall_left > 0) begin
        stall_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) free_left = $urandom_range(50, 150);
        else if (r >= 50) stall_left = pick_idle();
      end
      m_axis_tready_i <= !hold_off && (stall_left == 0);
    end
  end

  // Long receiver hold-off early in the directed rows, to fill the encoder.
  initial begin : hold_side
    while (hold_mark == 0 || accepted_words < hold_mark) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Reset, stimulus and end of run.
  initial begin : main_flow
    int kind;
    int len;
    sb              = new();
    accepted_words  = 0;
    hold_mark       = 0;
    last_sent       = 8'h00;
    hold_off        <= 1'b0;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= 8'h00;
    s_axis_tlast_i  <= 1'b0;
    m_axis_tready_i <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    hold_mark = accepted_words + 4;

    // Directed rows: single byte, a pair, a plain literal, run then single,
    // a broken pair inside a literal, literal into a run, a pair at row end.
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'hFF, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'h55, 1'b1, 1'b0);
    send_run(3, 8'hAA, 1'b0);
    send_word(8'h01, 1'b1, 1'b0);
    send_word(8'h10, 1'b0, 1'b0);
    send_word(8'h20, 1'b0, 1'b0);
    send_word(8'h20, 1'b0, 1'b0);
    send_word(8'h30, 1'b1, 1'b0);
    send_word(8'h10, 1'b0, 1'b0);
    send_word(8'h20, 1'b0, 1'b0);
    send_run(3, 8'h30, 1'b0);
    send_word(8'h40, 1'b1, 1'b0);
    send_word(8'h7F, 1'b0, 1'b0);
    send_run(2, 8'h80, 1'b1);

    // Size limits: a full run and a full literal, each ending its row on the
    // byte that fills it, then a pair arriving when the literal is one short.
    send_run(int'(MaxRun), 8'($urandom_range(0, 255)), 1'b1);
    send_distinct(int'(MaxLiteral), 1'b1);
    send_distinct(int'(MaxLiteral) - 1, 1'b0);
    send_word(last_sent, 1'b0, 1'b0);
    send_word(last_sent, 1'b1, 1'b0);

    // Random rows built from runs, literal stretches and noise.
    while (accepted_words < RandomItems) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: begin
          len = ($urandom_range(0, 99) < 5) ? $urandom_range(120, 140) : $urandom_range(1, 8);
          if (len > RandomItems - accepted_words) len = RandomItems - accepted_words;
          send_run(len, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        4, 5, 6: begin
          len = ($urandom_range(0, 99) < 5) ? $urandom_range(50, 66) : $urandom_range(1, 12);
          if (len > RandomItems - accepted_words) len = RandomItems - accepted_words;
          send_mixed(len, 1'($urandom_range(0, 1)));
        end
        7, 8: begin
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++) begin
            send_word(8'($urandom_range(0, 3)), 1'($urandom_range(0, 9) == 0),
                      1'($urandom_range(0, 1)));
          end
        end
        default: begin
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++) begin
            send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 9) < 3), 1'b0);
          end
        end
      endcase
    end
    // Close the last row so every pending packet comes out.
    send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    s_axis_tvalid_i <= 1'b0;

    while (sb.pending() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
